@@ rtl/qstok_pkg.sv @@
package qstok_pkg;

	localparam int unsigned SLOTS = 3;
	localparam int unsigned CNT_W = 2;

	typedef enum logic [2:0] {
		KIND_BYTE  = 3'd0,
		KIND_KEY   = 3'd1,
		KIND_VALUE = 3'd2,
		KIND_BARE  = 3'd3,
		KIND_EMPTY = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_D0    = 8'h30;
	localparam logic [7:0] CH_D9    = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
	} res_t;

	typedef struct packed {
		res_t [SLOTS-1:0]  slot;
		logic [CNT_W-1:0]  count;
	} group_t;

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c inside {[CH_D0:CH_D9]}) begin
			v = 4'(c - CH_D0);
		end else if (c inside {[CH_UA:CH_UF]}) begin
			v = 4'(c - CH_UA + 8'd10);
		end else if (c inside {[CH_LA:CH_LF]}) begin
			v = 4'(c - CH_LA + 8'd10);
		end
		return v;
	endfunction

	function automatic logic is_delim(input logic [7:0] c);
		return c inside {CH_EQ, CH_AMP, CH_SEMI, CH_HASH};
	endfunction

	function automatic logic [7:0] plain(input logic [7:0] c);
		return (c == CH_PLUS) ? CH_SPACE : c;
	endfunction

endpackage

@@ rtl/qstok_in_if.sv @@
interface qstok_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

@@ rtl/qstok_out_if.sv @@
interface qstok_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [2:0] out_kind;
	logic       out_last;

	modport source (output valid, output out_byte, output out_kind, output out_last,
		input ready);
	modport sink (input valid, input out_byte, input out_kind, input out_last,
		output ready);
endinterface

@@ rtl/query_string_tokenizer_url_decoder.sv @@
// Channel   Modport  Payload                        Transaction
// items     sink     in_byte[7:0], in_last          one query string byte
// results   source   out_byte[7:0], out_kind[2:0],  one decoded byte or segment marker
//                    out_last
//
// A byte is registered on entry and decoded in the next cycle into a group of zero to
// three results, which the output register hands out one per cycle while results is ready.
// Throughput is one byte per cycle when each byte yields at most one result and results
// is ready; a byte that yields k results occupies the output port until all k are taken.
// Bytes that only fill an escape produce no transaction and never wait for the output.
// Reset clears the escape state, the pending key flag and all valid flags.
// A stall on results holds the current group; the input register and ready back up
// behind it.
module query_string_tokenizer_url_decoder (
	input  logic         clk,
	input  logic         arst_n,
	qstok_in_if.sink     items,
	qstok_out_if.source  results
);
	import qstok_pkg::*;

	logic       valid_s1;
	item_t      item_s1;
	group_t     grp;
	logic       free;
	logic       advance;
	logic       load;

	assign advance     = valid_s1 && ((grp.count == '0) || free);
	assign load        = advance && (grp.count != '0);
	assign items.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			item_s1 <= '{data: items.in_byte, last: items.in_last};
		end
	end

	qstok_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.commit (advance),
		.grp    (grp)
	);

	qstok_serial u_serial (
		.clk     (clk),
		.arst_n  (arst_n),
		.grp     (grp),
		.load    (load),
		.free    (free),
		.results (results)
	);

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input register changed while stalled");

endmodule

@@ rtl/qstok_decode.sv @@
module qstok_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  qstok_pkg::item_t    item,
	input  logic                commit,
	output qstok_pkg::group_t   grp
);
	import qstok_pkg::*;

	phase_t     phase_q;
	logic [7:0] held_q;
	logic       key_q;

	phase_t     phase_d;
	logic [7:0] held_d;
	logic       key_d;
	logic [7:0] c;
	logic       last;
	logic       flush;

	assign c    = item.data;
	assign last = item.last;

	always_comb begin
		logic [2:0] n;
		n     = 3'd0;
		grp   = '0;
		flush = 1'b0;

		if (is_delim(c)) begin
			flush = 1'b1;
			if (phase_q == PH_PCT || phase_q == PH_DIGIT) begin
				grp.slot[n[1:0]] = '{data: CH_PCT, kind: KIND_BYTE};
				n = n + 3'd1;
			end
			if (phase_q == PH_DIGIT) begin
				grp.slot[n[1:0]] = '{data: plain(held_q), kind: KIND_BYTE};
				n = n + 3'd1;
			end
			if (c == CH_EQ) begin
				grp.slot[n[1:0]] = '{data: 8'd0, kind: last ? KIND_EMPTY : KIND_KEY};
			end else begin
				grp.slot[n[1:0]] = '{data: 8'd0, kind: key_q ? KIND_VALUE : KIND_BARE};
			end
			n = n + 3'd1;
		end else begin
			case (phase_q)
				PH_PCT: begin
					if (last) begin
						grp.slot[n[1:0]] = '{data: CH_PCT, kind: KIND_BYTE};
						n = n + 3'd1;
						grp.slot[n[1:0]] = '{data: plain(c), kind: KIND_BYTE};
						n = n + 3'd1;
					end
				end
				PH_DIGIT: begin
					grp.slot[n[1:0]] = '{data: {hex_value(held_q), hex_value(c)},
						kind: KIND_BYTE};
					n = n + 3'd1;
				end
				default: begin
					if (!(c == CH_PCT && !last)) begin
						grp.slot[n[1:0]] = '{data: plain(c), kind: KIND_BYTE};
						n = n + 3'd1;
					end
				end
			endcase
			if (last) begin
				grp.slot[n[1:0]] = '{data: 8'd0, kind: key_q ? KIND_VALUE : KIND_BARE};
				n = n + 3'd1;
			end
		end
		grp.count = n[CNT_W-1:0];
	end

	always_comb begin
		phase_d = phase_q;
		held_d  = held_q;
		key_d   = key_q;
		if (flush) begin
			phase_d = PH_IDLE;
			held_d  = 8'd0;
			key_d   = (c == CH_EQ) && !last;
		end else begin
			case (phase_q)
				PH_PCT: begin
					phase_d = PH_DIGIT;
					held_d  = c;
				end
				PH_DIGIT: begin
					phase_d = PH_IDLE;
					held_d  = 8'd0;
				end
				default: begin
					if (c == CH_PCT) begin
						phase_d = PH_PCT;
					end
				end
			endcase
		end
		if (last) begin
			phase_d = PH_IDLE;
			held_d  = 8'd0;
			key_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= 8'd0;
			key_q   <= 1'b0;
		end else if (commit) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			key_q   <= key_d;
		end
	end

	// The held character is only meaningful while one escape digit is pending.
	a_held_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_DIGIT |-> held_q == 8'd0)
		else $error("held digit not cleared outside an escape");

	// A transaction that ends the string leaves every piece of state at reset.
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		commit && last |=> phase_q == PH_IDLE && !key_q)
		else $error("state not cleared after end of string");

endmodule

@@ rtl/qstok_serial.sv @@
module qstok_serial (
	input  logic                clk,
	input  logic                arst_n,
	input  qstok_pkg::group_t   grp,
	input  logic                load,
	output logic                free,
	qstok_out_if.source         results
);
	import qstok_pkg::*;

	res_t [SLOTS-1:0]  slot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  idx_q;
	logic              take;
	logic              final_take;
	res_t              cur;

	assign cur              = slot_q[idx_q];
	assign results.valid    = cnt_q != '0;
	assign results.out_byte = cur.data;
	assign results.out_kind = cur.kind;
	assign results.out_last = idx_q == cnt_q - CNT_W'(1);

	assign take       = results.valid && results.ready;
	assign final_take = take && results.out_last;
	assign free       = (cnt_q == '0) || final_take;

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= grp.slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= grp.count;
			idx_q <= '0;
		end else if (final_take) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (take) begin
			idx_q <= idx_q + CNT_W'(1);
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free && grp.count != '0)
		else $error("result group loaded over an undelivered one");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 |-> idx_q < cnt_q)
		else $error("result index beyond group size");

endmodule

@@ tb/qstok_decode_check.sv @@
module qstok_decode_check (
	input  logic        clk,
	input  logic        arst_n,
	qstok_in_if         items,
	qstok_out_if        results,
	output int          fail_count,
	output int          outstanding,
	output int          compared
);

	import qstok_pkg::*;

	typedef struct {
		logic [7:0] data;
		kind_t      kind;
		logic       last;
	} want_t;

	want_t      want_q[$];
	phase_t     esc;
	logic [7:0] held;
	logic       key_open;

	function automatic logic is_separator(logic [7:0] c);
		return c == CH_EQ || c == CH_AMP || c == CH_SEMI || c == CH_HASH;
	endfunction

	// Digits and letters both carry their value in the low nibble, letters offset by 9.
	function automatic logic [3:0] nibble(logic [7:0] c);
		if (c >= CH_D0 && c <= CH_D9) begin
			return c[3:0];
		end
		if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF)) begin
			return c[3:0] + 4'd9;
		end
		return 4'd0;
	endfunction

	function automatic logic [7:0] literal(logic [7:0] c);
		return (c == CH_PLUS) ? CH_SPACE : c;
	endfunction

	function automatic void emit(logic [7:0] d, kind_t k);
		want_t w;
		w.data = d;
		w.kind = k;
		w.last = 1'b0;
		want_q.push_back(w);
	endfunction

	// An escape cut short by the end of its segment comes out as plain text.
	function automatic void flush_partial();
		if (esc == PH_PCT || esc == PH_DIGIT) begin
			emit(CH_PCT, KIND_BYTE);
		end
		if (esc == PH_DIGIT) begin
			emit(literal(held), KIND_BYTE);
		end
		esc = PH_IDLE;
		held = 8'h00;
	endfunction

	function automatic void decode_byte(logic [7:0] c, logic last);
		int unsigned base;
		base = want_q.size();
		if (is_separator(c)) begin
			flush_partial();
			if (c == CH_EQ) begin
				emit(8'h00, last ? KIND_EMPTY : KIND_KEY);
				key_open = !last;
			end else begin
				emit(8'h00, key_open ? KIND_VALUE : KIND_BARE);
				key_open = 1'b0;
			end
		end else begin
			case (esc)
			PH_PCT: begin
				if (last) begin
					emit(CH_PCT, KIND_BYTE);
					emit(literal(c), KIND_BYTE);
					esc = PH_IDLE;
					held = 8'h00;
				end else begin
					held = c;
					esc = PH_DIGIT;
				end
			end
			PH_DIGIT: begin
				emit({nibble(held), nibble(c)}, KIND_BYTE);
				esc = PH_IDLE;
				held = 8'h00;
			end
			default: begin
				if (c == CH_PCT && !last) begin
					esc = PH_PCT;
				end else begin
					emit(literal(c), KIND_BYTE);
				end
			end
			endcase
			if (last) begin
				flush_partial();
				emit(8'h00, key_open ? KIND_VALUE : KIND_BARE);
				key_open = 1'b0;
			end
		end
		if (last) begin
			esc = PH_IDLE;
			held = 8'h00;
			key_open = 1'b0;
		end
		if (want_q.size() > base) begin
			want_q[want_q.size() - 1].last = 1'b1;
		end
	endfunction

	function automatic void match_result(logic [7:0] d, logic [2:0] k, logic l);
		want_t w;
		if (want_q.size() == 0) begin
			$error("unexpected transaction: out_byte %02h out_kind %0d out_last %0b", d, k, l);
			fail_count++;
		end else begin
			w = want_q.pop_front();
			compared++;
			if (d !== w.data) begin
				$error("out_byte: expected %02h, actual %02h", w.data, d);
				fail_count++;
			end
			if (k !== w.kind) begin
				$error("out_kind: expected %0d, actual %0d", w.kind, k);
				fail_count++;
			end
			if (l !== w.last) begin
				$error("out_last: expected %0b, actual %0b", w.last, l);
				fail_count++;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			want_q.delete();
			esc = PH_IDLE;
			held = 8'h00;
			key_open = 1'b0;
			outstanding = 0;
			fail_count = 0;
			compared = 0;
		end else begin
			if (items.valid && items.ready) begin
				decode_byte(items.in_byte, items.in_last);
			end
			if (results.valid && results.ready) begin
				match_result(results.out_byte, results.out_kind, results.out_last);
			end
			outstanding = want_q.size();
		end
	end

endmodule

@@ tb/tb_top.sv @@
module tb_top;

	import qstok_pkg::*;

	localparam int unsigned LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	int          fail_count;
	int          outstanding;
	int          compared;
	int unsigned bytes_sent;
	int unsigned strings_sent;
	int unsigned cycles;
	bit          jitter;
	bit          hold_req;

	qstok_in_if  items();
	qstok_out_if results();

	query_string_tokenizer_url_decoder i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results)
	);

	qstok_decode_check i_decode_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.items       (items),
		.results     (results),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.compared    (compared)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Ready is stable by the falling edge, so the transaction completes at the next rising edge.
	task automatic send_byte(input logic [7:0] b, input logic l);
		if (jitter && $urandom_range(0, 7) == 0) begin
			items.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		items.valid <= 1'b1;
		items.in_byte <= b;
		items.in_last <= l;
		do @(negedge clk); while (!items.ready);
		@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_bytes(input logic [7:0] q[$]);
		foreach (q[i]) begin
			send_byte(q[i], i == q.size() - 1);
		end
		strings_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i], i == s.len() - 1);
		end
		strings_sent++;
	endtask

	function automatic logic [7:0] hex_char();
		string digits = "0123456789abcdefABCDEF";
		return digits[$urandom_range(0, digits.len() - 1)];
	endfunction

	function automatic logic [7:0] separator_char();
		case ($urandom_range(0, 3))
		0: return CH_EQ;
		1: return CH_AMP;
		2: return CH_SEMI;
		default: return CH_HASH;
		endcase
	endfunction

	function automatic void add_token(ref logic [7:0] q[$]);
		string alnum = "abcxyzKLMQ0189._-~";
		repeat ($urandom_range(0, 4)) begin
			case ($urandom_range(0, 19))
			0, 1, 2: q.push_back(CH_PLUS);
			3, 4, 5, 6: begin
				q.push_back(CH_PCT);
				q.push_back(hex_char());
				q.push_back(hex_char());
			end
			7: q.push_back(8'($urandom_range(0, 255)));
			default: q.push_back(alnum[$urandom_range(0, alnum.len() - 1)]);
			endcase
		end
	endfunction

	function automatic void build_query(ref logic [7:0] q[$]);
		int pairs;
		pairs = $urandom_range(1, 3);
		for (int i = 0; i < pairs; i++) begin
			if (i > 0) begin
				q.push_back(CH_AMP + 0 == 0 ? CH_AMP : separator_char());
			end
			add_token(q);
			if ($urandom_range(0, 4) != 0) begin
				q.push_back(CH_EQ);
				add_token(q);
			end
		end
		if (q.size() == 0 || $urandom_range(0, 7) == 0) begin
			q.push_back(separator_char());
		end
	endfunction

	function automatic void build_noise(ref logic [7:0] q[$]);
		repeat ($urandom_range(1, 8)) begin
			case ($urandom_range(0, 3))
			0: q.push_back(CH_PCT);
			1: q.push_back(separator_char());
			default: q.push_back(8'($urandom_range(0, 255)));
			endcase
		end
	endfunction

	task automatic send_random(input int unsigned count, input bit idle_ok);
		logic [7:0]  q[$];
		int unsigned stop;
		stop = bytes_sent + count;
		while (bytes_sent < stop) begin
			jitter = idle_ok && ($urandom_range(0, 3) != 0);
			q.delete();
			if ($urandom_range(0, 9) < 8) begin
				build_query(q);
			end else begin
				build_noise(q);
			end
			send_bytes(q);
		end
	endtask

	initial begin
		int unsigned stall;
		results.ready <= 1'b0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall = 80;
			end
			if (stall > 0) begin
				results.ready <= 1'b0;
				stall--;
			end else if (jitter && $urandom_range(0, 5) == 0) begin
				results.ready <= 1'b0;
				stall = $urandom_range(0, 5);
			end else begin
				results.ready <= 1'b1;
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL query_string_tokenizer_url_decoder");
		$finish;
	end

	initial begin
		logic [7:0] q[$];
		items.valid <= 1'b0;
		items.in_byte <= 8'h00;
		items.in_last <= 1'b0;
		arst_n <= 1'b0;
		jitter = 1'b0;
		hold_req = 1'b0;
		bytes_sent = 0;
		strings_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("%2f+=%+&%==;;#=");
		q = '{8'h00, CH_PCT, 8'hff, 8'h67, 8'hff};
		send_bytes(q);
		send_text("%Ff%");
		send_text("%4");

		send_random(130, 1'b1);

		// The output side stalls while bytes keep coming, so the input has to back up.
		hold_req = 1'b1;
		send_random(35, 1'b0);
		items.valid <= 1'b0;
		@(negedge clk);
		wait (outstanding == 0);
		@(posedge clk);

		send_random(95, 1'b1);
		send_random(60, 1'b0);
		items.valid <= 1'b0;
		@(negedge clk);
		wait (outstanding == 0);
		repeat (10) @(posedge clk);

		$display("Sent %0d bytes in %0d query strings, with short escapes, repeated and trailing",
			bytes_sent, strings_sent);
		$display("equals, empty segments and a long output stall; %0d results compared.",
			compared);
		if (fail_count == 0) begin
			$display("PASS query_string_tokenizer_url_decoder");
		end else begin
			$display("FAIL query_string_tokenizer_url_decoder");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/qstok_pkg.sv
rtl/qstok_in_if.sv
rtl/qstok_out_if.sv
rtl/qstok_decode.sv
rtl/qstok_serial.sv
rtl/query_string_tokenizer_url_decoder.sv
tb/qstok_decode_check.sv
tb/tb_top.sv
